// ----- hw/rtl/assert_macros.svh -----
// Assertion macros used by the checker file.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define LNP_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define LNP_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/lnp_pkg.sv -----
// Shared types, widths and helper functions for the last-note-priority key stack.
// No dependencies.
package lnp_pkg;

    localparam int SLOT_COUNT_DEF = 12;

    localparam int CMD_W   = 3;
    localparam int KEY_W   = 7;
    localparam int BEND_W  = 7;
    localparam int SENS_W  = 7;
    localparam int OFF_W   = 19;
    localparam int PITCH_W = 23;

    localparam int APB_ADDR_W = 2;
    localparam int APB_DATA_W = 32;

    localparam logic [SENS_W-1:0]     SENS_RESET    = 7'd64;
    localparam logic [APB_ADDR_W-1:0] ADDR_BEND_SENS = 2'd0;

    typedef enum logic [CMD_W-1:0] {
        CMD_NOTE_ON  = 3'd0,
        CMD_NOTE_OFF = 3'd1,
        CMD_BEND     = 3'd2,
        CMD_SUSTAIN  = 3'd3,
        CMD_ALL_OFF  = 3'd4
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FIN,
        ST_TOP,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic signed [PITCH_W-1:0] pitch;
        logic                      pitch_valid;
        logic                      gate;
        logic                      gate_valid;
        logic                      panic_level;
        logic                      panic_valid;
    } res_t;

    // key * 16384 + offset
    function automatic logic signed [PITCH_W-1:0] pitch_of(
        input logic [KEY_W-1:0]        k,
        input logic signed [OFF_W-1:0] off
    );
        logic signed [PITCH_W-1:0] base;
        base = $signed({2'b00, k, 14'b0});
        return base + PITCH_W'(off);
    endfunction

    // (bend - 64) * sens * 24
    function automatic logic signed [OFF_W-1:0] bend_offset_of(
        input logic [BEND_W-1:0] bv,
        input logic [SENS_W-1:0] sens
    );
        logic signed [BEND_W:0]   diff;
        logic signed [SENS_W:0]   sens_s;
        logic signed [15:0]       prod;
        logic signed [OFF_W-1:0]  prod_x;
        diff   = $signed({1'b0, bv}) - 8'sd64;
        sens_s = $signed({1'b0, sens});
        prod   = diff * sens_s;
        prod_x = OFF_W'(prod);
        return (prod_x <<< 4) + (prod_x <<< 3);
    endfunction

endpackage

// ----- hw/rtl/lnp_ram.sv -----
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module lnp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ----- hw/rtl/lnp_cfg.sv -----
// APB-style register block holding the bend sensitivity.
// Depends on lnp_pkg.
module lnp_cfg (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [lnp_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [lnp_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [lnp_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready,
    output logic [lnp_pkg::SENS_W-1:0]        sens
);

    logic [lnp_pkg::SENS_W-1:0] sens_reg;
    logic                       hit;

    assign pready = 1'b1;
    assign hit    = (paddr == lnp_pkg::ADDR_BEND_SENS);
    assign sens   = sens_reg;
    assign prdata = hit ? lnp_pkg::APB_DATA_W'(sens_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sens_reg <= lnp_pkg::SENS_RESET;
        end
        else if (psel && penable && pwrite && hit)
        begin
            sens_reg <= pwdata[lnp_pkg::SENS_W-1:0];
        end
    end

endmodule

// ----- hw/rtl/lnp_ctrl.sv -----
// Command sequencer: walks the key stack RAM, keeps bend, sustain and panic
// state, and holds the result register. Depends on lnp_pkg.
module lnp_ctrl #(
    parameter int SLOT_COUNT = lnp_pkg::SLOT_COUNT_DEF,
    localparam int AW = $clog2(SLOT_COUNT),
    localparam int CW = $clog2(SLOT_COUNT + 1)
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [lnp_pkg::SENS_W-1:0]  sens,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [lnp_pkg::CMD_W-1:0]   cmd,
    input  logic [lnp_pkg::KEY_W-1:0]   key,
    input  logic [lnp_pkg::BEND_W-1:0]  bend,
    input  logic                        sustain_on,
    input  logic                        any_key_held,
    output logic                        out_valid,
    input  logic                        out_stall,
    output lnp_pkg::res_t               res,
    output logic                        ram_wr_en,
    output logic [AW-1:0]               ram_wr_addr,
    output logic [lnp_pkg::KEY_W-1:0]   ram_wr_data,
    output logic                        ram_rd_en,
    output logic [AW-1:0]               ram_rd_addr,
    input  logic [lnp_pkg::KEY_W-1:0]   ram_rd_data
);

    localparam logic [CW-1:0] FULL     = CW'(SLOT_COUNT);
    localparam logic [AW-1:0] TOP_ADDR = AW'(SLOT_COUNT - 1);

    lnp_pkg::state_t                    state_reg, state_next;
    lnp_pkg::cmd_t                      cmd_reg, cmd_next;
    logic [lnp_pkg::KEY_W-1:0]          key_reg, key_next;
    logic [lnp_pkg::BEND_W-1:0]         bend_reg, bend_next;
    logic                               sus_reg, sus_next;
    logic                               held_reg, held_next;
    logic [CW-1:0]                      cnt_reg, cnt_next;
    logic [CW-1:0]                      rd_idx_reg, rd_idx_next;
    logic                               pend_reg, pend_next;
    logic [AW-1:0]                      pend_idx_reg, pend_idx_next;
    logic                               found_reg, found_next;
    logic signed [lnp_pkg::OFF_W-1:0]   offset_reg, offset_next;
    logic                               sustain_reg, sustain_next;
    logic                               armed_reg, armed_next;
    lnp_pkg::res_t                      work_reg, work_next;
    lnp_pkg::res_t                      out_reg, out_next;
    logic                               out_valid_reg, out_valid_next;

    logic                               accept;
    logic [CW-1:0]                      cnt_less;
    logic [CW-1:0]                      top_idx;

    assign accept    = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign res       = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lnp_pkg::ST_IDLE;
            cnt_reg       <= '0;
            rd_idx_reg    <= '0;
            pend_reg      <= 1'b0;
            found_reg     <= 1'b0;
            offset_reg    <= '0;
            sustain_reg   <= 1'b0;
            armed_reg     <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            rd_idx_reg    <= rd_idx_next;
            pend_reg      <= pend_next;
            found_reg     <= found_next;
            offset_reg    <= offset_next;
            sustain_reg   <= sustain_next;
            armed_reg     <= armed_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        key_reg      <= key_next;
        bend_reg     <= bend_next;
        sus_reg      <= sus_next;
        held_reg     <= held_next;
        pend_idx_reg <= pend_idx_next;
        work_reg     <= work_next;
        out_reg      <= out_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        key_next       = key_reg;
        bend_next      = bend_reg;
        sus_next       = sus_reg;
        held_next      = held_reg;
        cnt_next       = cnt_reg;
        rd_idx_next    = rd_idx_reg;
        pend_next      = pend_reg;
        pend_idx_next  = pend_idx_reg;
        found_next     = found_reg;
        offset_next    = offset_reg;
        sustain_next   = sustain_reg;
        armed_next     = armed_reg;
        work_next      = work_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && out_stall;

        in_stall    = (state_reg != lnp_pkg::ST_IDLE);
        ram_wr_en   = 1'b0;
        ram_wr_addr = AW'(pend_idx_reg - 1'b1);
        ram_wr_data = ram_rd_data;
        ram_rd_en   = 1'b0;
        ram_rd_addr = rd_idx_reg[AW-1:0];

        cnt_less = found_reg ? cnt_reg - 1'b1 : cnt_reg;
        top_idx  = '0;

        unique case (state_reg)
            lnp_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    cmd_next   = lnp_pkg::cmd_t'(cmd);
                    key_next   = key;
                    bend_next  = bend;
                    sus_next   = sustain_on;
                    held_next  = any_key_held;
                    work_next  = '0;
                    found_next = 1'b0;
                    pend_next  = 1'b0;
                    state_next = lnp_pkg::ST_FIN;
                    if (lnp_pkg::cmd_t'(cmd) == lnp_pkg::CMD_NOTE_ON && cnt_reg == FULL)
                    begin
                        // full stack: drop the oldest, shift everything down
                        found_next  = 1'b1;
                        rd_idx_next = CW'(1);
                        state_next  = lnp_pkg::ST_SCAN;
                    end
                    else if (lnp_pkg::cmd_t'(cmd) == lnp_pkg::CMD_NOTE_OFF && !sustain_reg)
                    begin
                        rd_idx_next = '0;
                        state_next  = lnp_pkg::ST_SCAN;
                    end
                end
            end

            lnp_pkg::ST_SCAN:
            begin
                // data returned for pend_idx; slots above a removed one move down
                if (pend_reg)
                begin
                    if (found_reg)
                    begin
                        ram_wr_en = 1'b1;
                    end
                    else if (ram_rd_data == key_reg)
                    begin
                        found_next = 1'b1;
                    end
                end
                if (rd_idx_reg < cnt_reg)
                begin
                    ram_rd_en     = 1'b1;
                    pend_next     = 1'b1;
                    pend_idx_next = rd_idx_reg[AW-1:0];
                    rd_idx_next   = rd_idx_reg + 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                    if (!pend_reg)
                    begin
                        state_next = lnp_pkg::ST_FIN;
                    end
                end
            end

            lnp_pkg::ST_FIN:
            begin
                state_next = lnp_pkg::ST_EMIT;
                case (cmd_reg)
                    lnp_pkg::CMD_NOTE_ON:
                    begin
                        if (!armed_reg)
                        begin
                            armed_next            = 1'b1;
                            work_next.panic_level = 1'b1;
                            work_next.panic_valid = 1'b1;
                        end
                        work_next.pitch       = lnp_pkg::pitch_of(key_reg, offset_reg);
                        work_next.pitch_valid = 1'b1;
                        work_next.gate        = 1'b1;
                        work_next.gate_valid  = 1'b1;
                        ram_wr_data           = key_reg;
                        if (found_reg)
                        begin
                            ram_wr_en   = 1'b1;
                            ram_wr_addr = TOP_ADDR;
                            cnt_next    = (key_reg == '0) ? FULL - 1'b1 : FULL;
                        end
                        else if (key_reg != '0)
                        begin
                            ram_wr_en   = 1'b1;
                            ram_wr_addr = cnt_reg[AW-1:0];
                            cnt_next    = cnt_reg + 1'b1;
                        end
                    end
                    lnp_pkg::CMD_NOTE_OFF:
                    begin
                        cnt_next = cnt_less;
                        top_idx  = cnt_less - 1'b1;
                        if (!held_reg)
                        begin
                            work_next.gate_valid = 1'b1;
                        end
                        else if (cnt_less != '0)
                        begin
                            ram_rd_en   = 1'b1;
                            ram_rd_addr = top_idx[AW-1:0];
                            state_next  = lnp_pkg::ST_TOP;
                        end
                    end
                    lnp_pkg::CMD_BEND:
                    begin
                        offset_next = lnp_pkg::bend_offset_of(bend_reg, sens);
                        top_idx     = cnt_reg - 1'b1;
                        if (cnt_reg != '0)
                        begin
                            ram_rd_en   = 1'b1;
                            ram_rd_addr = top_idx[AW-1:0];
                            state_next  = lnp_pkg::ST_TOP;
                        end
                    end
                    lnp_pkg::CMD_SUSTAIN:
                    begin
                        if (sustain_reg && !sus_reg)
                        begin
                            cnt_next = '0;
                        end
                        sustain_next = sus_reg;
                    end
                    lnp_pkg::CMD_ALL_OFF:
                    begin
                        cnt_next              = '0;
                        armed_next            = 1'b0;
                        work_next.gate_valid  = 1'b1;
                        work_next.panic_valid = 1'b1;
                    end
                    default:
                    begin
                    end
                endcase
            end

            lnp_pkg::ST_TOP:
            begin
                work_next.pitch       = lnp_pkg::pitch_of(ram_rd_data, offset_reg);
                work_next.pitch_valid = 1'b1;
                state_next            = lnp_pkg::ST_EMIT;
            end

            lnp_pkg::ST_EMIT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_next       = work_reg;
                    out_valid_next = 1'b1;
                    state_next     = lnp_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = lnp_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ----- hw/rtl/last_note_priority_key_stack.sv -----
// Last-note-priority key stack. One request at a time; an accepted request runs a slot walk
// (SCAN: note off without sustain, note on into a full stack), then FIN, then a newest-key
// read (TOP: bend, or held-key note off, with keys left), then EMIT loads the result.
// Next request is taken the cycle after the result loads; a stalled result holds the block.
// Reset (rst_n low, async) empties the stack at once via the fill count,
// zeroes the bend offset, clears sustain, arms panic and sets sensitivity 64.
module last_note_priority_key_stack #(
    parameter int SLOT_COUNT = lnp_pkg::SLOT_COUNT_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [lnp_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [lnp_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [lnp_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                pready,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [lnp_pkg::CMD_W-1:0]           cmd,
    input  logic [lnp_pkg::KEY_W-1:0]           key,
    input  logic [lnp_pkg::BEND_W-1:0]          bend,
    input  logic                                sustain_on,
    input  logic                                any_key_held,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [lnp_pkg::PITCH_W-1:0]  pitch,
    output logic                                pitch_valid,
    output logic                                gate,
    output logic                                gate_valid,
    output logic                                panic_level,
    output logic                                panic_valid
);

    localparam int AW = $clog2(SLOT_COUNT);

    logic [lnp_pkg::SENS_W-1:0] sens;
    lnp_pkg::res_t              res;
    logic                       ram_wr_en;
    logic [AW-1:0]              ram_wr_addr;
    logic [lnp_pkg::KEY_W-1:0]  ram_wr_data;
    logic                       ram_rd_en;
    logic [AW-1:0]              ram_rd_addr;
    logic [lnp_pkg::KEY_W-1:0]  ram_rd_data;

    lnp_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .sens    (sens)
    );

    lnp_ram #(
        .WIDTH (lnp_pkg::KEY_W),
        .DEPTH (SLOT_COUNT)
    ) u_slots (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    lnp_ctrl #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .sens         (sens),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .cmd          (cmd),
        .key          (key),
        .bend         (bend),
        .sustain_on   (sustain_on),
        .any_key_held (any_key_held),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .res          (res),
        .ram_wr_en    (ram_wr_en),
        .ram_wr_addr  (ram_wr_addr),
        .ram_wr_data  (ram_wr_data),
        .ram_rd_en    (ram_rd_en),
        .ram_rd_addr  (ram_rd_addr),
        .ram_rd_data  (ram_rd_data)
    );

    assign pitch       = res.pitch;
    assign pitch_valid = res.pitch_valid;
    assign gate        = res.gate;
    assign gate_valid  = res.gate_valid;
    assign panic_level = res.panic_level;
    assign panic_valid = res.panic_valid;

endmodule

// ----- hw/rtl/lnp_checker.sv -----
// Port-level assertions for the key stack, bound to the top level.
// Depends on assert_macros.svh and lnp_pkg.
`include "assert_macros.svh"

module lnp_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                in_valid,
    input logic                                in_stall,
    input logic                                out_valid,
    input logic                                out_stall,
    input logic signed [lnp_pkg::PITCH_W-1:0]  pitch,
    input logic                                pitch_valid,
    input logic                                gate,
    input logic                                gate_valid,
    input logic                                panic_level,
    input logic                                panic_valid
);

    // one request in flight: the block is busy right after taking one
    `LNP_ASSERT_NXT(a_busy_after_req, clk, rst_n, in_valid && !in_stall, in_stall, "accepted while busy")

    // a result held under stall keeps its pitch, gate_valid and panic_valid
    `LNP_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(pitch) && $stable(gate_valid) && $stable(panic_valid), "stalled result changed")

    // fields without their valid bit read as zero
    `LNP_ASSERT_IMP(a_zero_fill, clk, rst_n, out_valid, (pitch_valid || pitch == '0) && (gate_valid || !gate) && (panic_valid || !panic_level), "field set without valid")

    // panic off only comes from all-sound-off: gate low, no pitch
    `LNP_ASSERT_IMP(a_panic_off, clk, rst_n, out_valid && panic_valid && !panic_level, !pitch_valid && gate_valid && !gate, "panic off with wrong companions")

endmodule

bind last_note_priority_key_stack lnp_checker u_lnp_checker (.*);

// ----- tb/tb_last_note_priority_key_stack.sv -----
// Self-checking testbench for last_note_priority_key_stack: random and directed MIDI-style
// requests, APB bend sensitivity setup, results checked against an in-bench voice predictor.
// Depends on lnp_pkg and the block RTL only.
module tb_last_note_priority_key_stack;
    timeunit 1ns;
    timeprecision 1ps;

    import lnp_pkg::*;

    localparam int SLOTS           = SLOT_COUNT_DEF;
    localparam int PHASES          = 6;
    localparam int PHASE_REQUESTS  = 325;
    localparam int QUIET_LIMIT     = 2000;
    localparam int SETTLE_CYCLES   = SLOTS + 8;
    localparam logic [CMD_W-1:0] CMD_RSVD_FIRST = 3'd5;
    localparam logic [CMD_W-1:0] CMD_RSVD_LAST  = 3'd7;

    // Voice predictor plus queue of expected results, one per accepted request.
    class key_stack_scoreboard;
        logic [KEY_W-1:0]  slots [SLOTS];
        int                bend_ofs;
        bit                sustain;
        bit                panic_armed;
        logic [SENS_W-1:0] sens;
        res_t              pending_voice [$];
        int                errors;

        function new();
            foreach (slots[i])
                slots[i] = '0;
            bend_ofs    = 0;
            sustain     = 0;
            panic_armed = 1;
            sens        = SENS_RESET;
            errors      = 0;
        endfunction

        function void clear_stack();
            foreach (slots[i])
                slots[i] = '0;
        endfunction

        function void remove_at(int pos);
            for (int i = pos; i < SLOTS - 1; i++)
                slots[i] = slots[i + 1];
            slots[SLOTS - 1] = '0;
        endfunction

        function logic signed [PITCH_W-1:0] pitch_for(logic [KEY_W-1:0] k);
            int p;
            p = int'(k) * 16384 + bend_ofs;
            return p[PITCH_W-1:0];
        endfunction

        // newest non-empty slot, if any
        function void emit_newest(inout res_t r);
            bit found;
            found = 0;
            for (int i = SLOTS - 1; i >= 0; i--)
            begin
                if (!found && slots[i] != '0)
                begin
                    r.pitch       = pitch_for(slots[i]);
                    r.pitch_valid = 1'b1;
                    found         = 1;
                end
            end
        endfunction

        function res_t apply_midi_event(logic [CMD_W-1:0] c, logic [KEY_W-1:0] k,
                                        logic [BEND_W-1:0] b, logic s, logic h);
            res_t r;
            bit   done;
            r    = '0;
            done = 0;
            case (c)
                CMD_NOTE_ON:
                begin
                    for (int i = 0; i < SLOTS; i++)
                    begin
                        if (!done && slots[i] == '0)
                        begin
                            slots[i] = k;
                            done     = 1;
                        end
                    end
                    if (!done)
                    begin
                        remove_at(0);
                        slots[SLOTS - 1] = k;
                    end
                    if (!panic_armed)
                    begin
                        panic_armed   = 1;
                        r.panic_level = 1'b1;
                        r.panic_valid = 1'b1;
                    end
                    r.pitch       = pitch_for(k);
                    r.pitch_valid = 1'b1;
                    r.gate        = 1'b1;
                    r.gate_valid  = 1'b1;
                end
                CMD_NOTE_OFF:
                begin
                    if (!sustain)
                    begin
                        for (int i = 0; i < SLOTS; i++)
                        begin
                            if (!done && slots[i] == k)
                            begin
                                remove_at(i);
                                done = 1;
                            end
                        end
                    end
                    if (!h)
                        r.gate_valid = 1'b1;
                    else
                        emit_newest(r);
                end
                CMD_BEND:
                begin
                    bend_ofs = (int'(b) - 64) * int'(sens) * 24;
                    emit_newest(r);
                end
                CMD_SUSTAIN:
                begin
                    if (sustain && !s)
                        clear_stack();
                    sustain = s;
                end
                CMD_ALL_OFF:
                begin
                    clear_stack();
                    panic_armed   = 0;
                    r.gate_valid  = 1'b1;
                    r.panic_valid = 1'b1;
                end
                default: ;
            endcase
            return r;
        endfunction

        function void note_request(logic [CMD_W-1:0] c, logic [KEY_W-1:0] k,
                                   logic [BEND_W-1:0] b, logic s, logic h);
            pending_voice.push_back(apply_midi_event(c, k, b, s, h));
        endfunction

        function void check_field(string what, int exp_val, int act_val);
            if (exp_val != act_val)
            begin
                $display("%0t: %s mismatch: expected %0d, got %0d",
                         $time, what, exp_val, act_val);
                errors++;
            end
        endfunction

        function void check_result(res_t got);
            res_t want;
            if (pending_voice.size() == 0)
            begin
                $display("%0t: result with no request waiting: expected none, got pitch %0d",
                         $time, int'(got.pitch));
                errors++;
                return;
            end
            want = pending_voice.pop_front();
            check_field("pitch", int'(want.pitch), int'(got.pitch));
            check_field("pitch_valid", want.pitch_valid, got.pitch_valid);
            check_field("gate", want.gate, got.gate);
            check_field("gate_valid", want.gate_valid, got.gate_valid);
            check_field("panic_level", want.panic_level, got.panic_level);
            check_field("panic_valid", want.panic_valid, got.panic_valid);
        endfunction

        function logic [KEY_W-1:0] pick_held_key();
            logic [KEY_W-1:0] held_keys [$];
            foreach (slots[i])
                if (slots[i] != '0)
                    held_keys.push_back(slots[i]);
            if (held_keys.size() == 0)
                return KEY_W'($urandom_range(1, 127));
            return held_keys[$urandom_range(0, held_keys.size() - 1)];
        endfunction
    endclass

    logic                       clk = 1'b0;
    logic                       rst_n;
    logic                       psel;
    logic                       penable;
    logic                       pwrite;
    logic [APB_ADDR_W-1:0]      paddr;
    logic [APB_DATA_W-1:0]      pwdata;
    logic [APB_DATA_W-1:0]      prdata;
    logic                       pready;
    logic                       in_valid;
    logic                       in_stall;
    logic [CMD_W-1:0]           cmd;
    logic [KEY_W-1:0]           key;
    logic [BEND_W-1:0]          bend;
    logic                       sustain_on;
    logic                       any_key_held;
    logic                       out_valid;
    logic                       out_stall;
    logic signed [PITCH_W-1:0]  pitch;
    logic                       pitch_valid;
    logic                       gate;
    logic                       gate_valid;
    logic                       panic_level;
    logic                       panic_valid;

    bit                  allow_idle;
    key_stack_scoreboard sb = new();

    last_note_priority_key_stack #(.SLOT_COUNT(SLOTS)) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .cmd          (cmd),
        .key          (key),
        .bend         (bend),
        .sustain_on   (sustain_on),
        .any_key_held (any_key_held),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .pitch        (pitch),
        .pitch_valid  (pitch_valid),
        .gate         (gate),
        .gate_valid   (gate_valid),
        .panic_level  (panic_level),
        .panic_valid  (panic_valid)
    );

    always #5 clk = ~clk;

    // Accepted requests feed the predictor before a same-edge result is checked.
    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
            sb.note_request(cmd, key, bend, sustain_on, any_key_held);
        if (rst_n && out_valid && !out_stall)
            sb.check_result('{pitch, pitch_valid, gate, gate_valid, panic_level, panic_valid});
    end

    // Result-side backpressure in random bursts, enabled with allow_idle.
    initial
    begin
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (allow_idle && $urandom_range(0, 5) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 3)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    initial
    begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("%0t: no progress for %0d cycles", $time, QUIET_LIMIT);
        $display("Simulation FAILED");
        $finish;
    end

    task automatic send_request(input logic [CMD_W-1:0] c, input logic [KEY_W-1:0] k,
                                input logic [BEND_W-1:0] b, input logic s, input logic h);
        if (allow_idle && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        in_valid     <= 1'b1;
        cmd          <= c;
        key          <= k;
        bend         <= b;
        sustain_on   <= s;
        any_key_held <= h;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    task automatic random_request();
        logic [CMD_W-1:0]  c;
        logic [KEY_W-1:0]  k;
        logic [BEND_W-1:0] b;
        logic              s;
        logic              h;
        int                pick;
        k    = KEY_W'($urandom_range(0, 127));
        b    = BEND_W'($urandom_range(0, 127));
        s    = $urandom_range(0, 1);
        h    = $urandom_range(0, 1);
        pick = $urandom_range(0, 99);
        if (pick < 40)
        begin
            c = CMD_NOTE_ON;
            // narrow key pool so note offs usually find their key
            if ($urandom_range(0, 3) != 0)
                k = KEY_W'($urandom_range(48, 62));
        end
        else if (pick < 70)
        begin
            c = CMD_NOTE_OFF;
            if ($urandom_range(0, 4) != 0)
                k = sb.pick_held_key();
            h = ($urandom_range(0, 3) != 0);
        end
        else if (pick < 82)
            c = CMD_BEND;
        else if (pick < 92)
            c = CMD_SUSTAIN;
        else if (pick < 96)
            c = CMD_ALL_OFF;
        else
            c = CMD_W'($urandom_range(CMD_RSVD_FIRST, CMD_RSVD_LAST));
        send_request(c, k, b, s, h);
    endtask

    task automatic set_sensitivity(input logic [SENS_W-1:0] v);
        logic [APB_DATA_W-1:0] readback;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_BEND_SENS;
        pwdata  <= APB_DATA_W'(v);
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        sb.sens = v;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        readback = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        sb.check_field("bend_sensitivity readback", int'(v), int'(readback));
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending_voice.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        logic [SENS_W-1:0] sens_plan [PHASES];
        rst_n        <= 1'b0;
        psel         <= 1'b0;
        penable      <= 1'b0;
        pwrite       <= 1'b0;
        paddr        <= '0;
        pwdata       <= '0;
        in_valid     <= 1'b0;
        cmd          <= CMD_NOTE_ON;
        key          <= '0;
        bend         <= '0;
        sustain_on   <= 1'b0;
        any_key_held <= 1'b0;
        allow_idle   = 1;
        sens_plan    = '{7'd127, 7'd0, 7'd1, SENS_W'($urandom_range(2, 126)), 7'd64, 7'd127};
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part at reset sensitivity
        send_request(CMD_BEND, 7'd0, 7'd0, 1'b0, 1'b1);        // empty stack, no pitch
        send_request(CMD_NOTE_ON, 7'd0, 7'd64, 1'b0, 1'b1);    // key zero on empty stack
        send_request(CMD_NOTE_ON, 7'd127, 7'd64, 1'b1, 1'b0);
        send_request(CMD_BEND, 7'd127, 7'd127, 1'b0, 1'b0);
        send_request(CMD_NOTE_OFF, 7'd55, 7'd0, 1'b0, 1'b1);   // absent key
        send_request(CMD_NOTE_OFF, 7'd127, 7'd0, 1'b0, 1'b0);
        for (int i = 0; i < SLOTS; i++)
            send_request(CMD_NOTE_ON, KEY_W'(100 + i), 7'd0, 1'b0, 1'b0);
        send_request(CMD_NOTE_ON, 7'd0, 7'd0, 1'b0, 1'b0);     // key zero on full stack
        send_request(CMD_SUSTAIN, 7'd0, 7'd0, 1'b1, 1'b0);
        send_request(CMD_NOTE_OFF, 7'd111, 7'd0, 1'b0, 1'b1);  // sustained, key stays
        send_request(CMD_SUSTAIN, 7'd0, 7'd0, 1'b0, 1'b1);     // release clears stack
        send_request(CMD_BEND, 7'd0, 7'd64, 1'b0, 1'b0);
        send_request(CMD_ALL_OFF, 7'd127, 7'd127, 1'b1, 1'b1);
        send_request(CMD_NOTE_ON, 7'd64, 7'd0, 1'b0, 1'b0);    // re-arms panic
        send_request(CMD_RSVD_FIRST, 7'd127, 7'd127, 1'b1, 1'b1);
        send_request(CMD_RSVD_LAST, 7'd0, 7'd0, 1'b0, 1'b0);
        drain();

        for (int ph = 0; ph < PHASES; ph++)
        begin
            allow_idle = (ph != 2) && (ph != PHASES - 1);
            set_sensitivity(sens_plan[ph]);
            @(posedge clk);
            for (int n = 0; n < PHASE_REQUESTS; n++)
                random_request();
            drain();
        end

        if (sb.errors == 0 && sb.pending_voice.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule
